FILE: rtl/core/tsac_pkg.sv
`timescale 1ns / 1ps

package tsac_pkg;

  // Field and datapath widths
  localparam int unsigned RawW    = 13;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 7;
  localparam int unsigned SumW    = 19;
  localparam int unsigned GainW   = 17;
  localparam int unsigned DiffW   = RawW + 1;
  localparam int unsigned ProdW   = DiffW + GainW;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CoordW  = ProdW - FracW;
  localparam int unsigned StepW   = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = GainW;
  localparam int unsigned InDataW  = 4 * ByteW;
  localparam int unsigned OutDataW = 56;

  // Averaging limit and last divider step
  localparam logic [CountW-1:0] MaxSamples = 7'd64;
  localparam logic [StepW-1:0]  DivLast    = 5'(SumW - 1);

  // Reset values of the configuration registers
  localparam logic [CountW-1:0]       SampleCountRst = 7'd20;
  localparam logic [RawW-1:0]         OffsetRst      = 13'd3800;
  localparam logic signed [GainW-1:0] GainXRst       = -17'sd4495;
  localparam logic signed [GainW-1:0] GainYRst       = -17'sd6168;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_OFFSET_X     = 3'd1,
    REG_OFFSET_Y     = 3'd2,
    REG_GAIN_X       = 3'd3,
    REG_GAIN_Y       = 3'd4
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_OUT
  } tsac_state_e;

  // Rebuild a 13-bit conversion value from its two reply bytes
  function automatic logic [RawW-1:0] raw_value(input logic [ByteW-1:0] hi,
                                                input logic [ByteW-1:0] lo);
    raw_value = {hi, lo[7:3]};
  endfunction

endpackage

FILE: rtl/core/touch_sample_average_calibrate.sv
`timescale 1ns / 1ps
// Processing: a completing pair goes through restoring division (one quotient bit per
// cycle, divider shared by X and Y), then multiply and clamp (multiplier shared by X
// and Y), then a load of the output register, which raises tvalid.
// Throughput: one pair per cycle while accumulating; after a completing pair tready stays low
// until the result is loaded, longer while the previous result is still waiting.
// Reset: asynchronous, active low; clears sums and counter, loads register defaults.
module touch_sample_average_calibrate (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [tsac_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tsac_pkg::CfgW-1:0]       cfg_wdata_i,
  // Input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // y_high[7:0], y_low[15:8], x_high[23:16], x_low[31:24]
  input  logic [tsac_pkg::InDataW-1:0]    s_axis_tdata,
  // Output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // avg_x[12:0], avg_y[25:13], pixel_x[38:26], pixel_y[51:39], zero[55:52]
  output logic [tsac_pkg::OutDataW-1:0]   m_axis_tdata
);

  tsac_pkg::tsac_state_e state_q, state_d;

  // Configuration registers
  logic [tsac_pkg::CountW-1:0]       sample_count_q;
  logic [tsac_pkg::RawW-1:0]         offset_x_q, offset_y_q;
  logic signed [tsac_pkg::GainW-1:0] gain_x_q, gain_y_q;

  // Accumulation state
  logic [tsac_pkg::SumW-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [tsac_pkg::CountW-1:0] cnt_q, cnt_d;

  // Shared divider and multiplier
  logic [tsac_pkg::CountW-1:0]       div_n_q, div_n_d;
  logic [tsac_pkg::SumW-1:0]         dq_q, dq_d, dq_step;
  logic [tsac_pkg::CountW-1:0]       rem_q, rem_d, rem_step;
  logic [tsac_pkg::CountW:0]         rem_sh;
  logic                              rem_ge;
  logic [tsac_pkg::StepW-1:0]        step_q, step_d;
  logic                              sel_q, sel_d;
  logic signed [tsac_pkg::ProdW-1:0] prod_q, prod_d;
  logic signed [tsac_pkg::DiffW-1:0] diff;
  logic signed [tsac_pkg::GainW-1:0] gain_sel;
  logic signed [tsac_pkg::CoordW-1:0] coord;
  logic [tsac_pkg::RawW-1:0]         coord_sat;

  // Result registers
  logic [tsac_pkg::RawW-1:0] avg_x_q, avg_x_d, avg_y_q, avg_y_d;
  logic [tsac_pkg::RawW-1:0] pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic                      m_valid_q, m_valid_d;
  logic [tsac_pkg::OutDataW-1:0] m_data_q, m_data_d;

  // Pair handling
  logic                        s_fire, out_free, pair_done;
  logic [tsac_pkg::RawW-1:0]   raw_x, raw_y;
  logic [tsac_pkg::SumW-1:0]   sum_x_acc, sum_y_acc;
  logic [tsac_pkg::CountW-1:0] cnt_inc, need;

  assign s_axis_tready = (state_q == tsac_pkg::ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // Accumulate the incoming pair
  assign raw_y     = tsac_pkg::raw_value(s_axis_tdata[7:0], s_axis_tdata[15:8]);
  assign raw_x     = tsac_pkg::raw_value(s_axis_tdata[23:16], s_axis_tdata[31:24]);
  assign sum_x_acc = sum_x_q + tsac_pkg::SumW'(raw_x);
  assign sum_y_acc = sum_y_q + tsac_pkg::SumW'(raw_y);
  assign cnt_inc   = cnt_q + 7'd1;

  // Clip the programmed pair count to 1..MaxSamples
  always_comb begin
    if (sample_count_q == '0) begin
      need = 7'd1;
    end else if (sample_count_q > tsac_pkg::MaxSamples) begin
      need = tsac_pkg::MaxSamples;
    end else begin
      need = sample_count_q;
    end
  end
  assign pair_done = (cnt_inc >= need);

  // One restoring division step
  assign rem_sh   = {rem_q, dq_q[tsac_pkg::SumW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_n_q});
  assign rem_step = rem_ge ? tsac_pkg::CountW'(rem_sh - {1'b0, div_n_q})
                           : rem_sh[tsac_pkg::CountW-1:0];
  assign dq_step  = {dq_q[tsac_pkg::SumW-2:0], rem_ge};

  // Calibration operands for the selected axis
  assign diff     = sel_q ? $signed({1'b0, avg_y_q}) - $signed({1'b0, offset_y_q})
                          : $signed({1'b0, avg_x_q}) - $signed({1'b0, offset_x_q});
  assign gain_sel = sel_q ? gain_y_q : gain_x_q;

  // Floor shift, then clamp to 0..8191
  assign coord = prod_q[tsac_pkg::ProdW-1:tsac_pkg::FracW];
  always_comb begin
    if (coord[tsac_pkg::CoordW-1]) begin
      coord_sat = '0;
    end else if (coord[tsac_pkg::CoordW-2]) begin
      coord_sat = '1;
    end else begin
      coord_sat = coord[tsac_pkg::RawW-1:0];
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsac_pkg::ST_IDLE: begin
        if (s_fire && pair_done) state_d = tsac_pkg::ST_DIV;
      end
      tsac_pkg::ST_DIV: begin
        if (step_q == tsac_pkg::DivLast && sel_q) state_d = tsac_pkg::ST_MUL;
      end
      tsac_pkg::ST_MUL: state_d = tsac_pkg::ST_SAT;
      tsac_pkg::ST_SAT: begin
        state_d = sel_q ? tsac_pkg::ST_OUT : tsac_pkg::ST_MUL;
      end
      tsac_pkg::ST_OUT: begin
        if (out_free) state_d = tsac_pkg::ST_IDLE;
      end
      default: state_d = tsac_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates per state
  always_comb begin
    sum_x_d   = sum_x_q;
    sum_y_d   = sum_y_q;
    cnt_d     = cnt_q;
    div_n_d   = div_n_q;
    dq_d      = dq_q;
    rem_d     = rem_q;
    step_d    = step_q;
    sel_d     = sel_q;
    prod_d    = prod_q;
    avg_x_d   = avg_x_q;
    avg_y_d   = avg_y_q;
    pix_x_d   = pix_x_q;
    pix_y_d   = pix_y_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    unique case (state_q)
      tsac_pkg::ST_IDLE: begin
        if (s_fire) begin
          sum_x_d = sum_x_acc;
          sum_y_d = sum_y_acc;
          cnt_d   = cnt_inc;
          if (pair_done) begin
            div_n_d = cnt_inc;
            dq_d    = sum_x_acc;
            rem_d   = '0;
            step_d  = '0;
            sel_d   = 1'b0;
          end
        end
      end
      tsac_pkg::ST_DIV: begin
        dq_d   = dq_step;
        rem_d  = rem_step;
        step_d = step_q + 5'd1;
        if (step_q == tsac_pkg::DivLast) begin
          step_d = '0;
          rem_d  = '0;
          if (!sel_q) begin
            avg_x_d = dq_step[tsac_pkg::RawW-1:0];
            dq_d    = sum_y_q;
            sel_d   = 1'b1;
          end else begin
            avg_y_d = dq_step[tsac_pkg::RawW-1:0];
            sel_d   = 1'b0;
          end
        end
      end
      tsac_pkg::ST_MUL: begin
        prod_d = tsac_pkg::ProdW'(diff) * tsac_pkg::ProdW'(gain_sel);
      end
      tsac_pkg::ST_SAT: begin
        if (!sel_q) begin
          pix_x_d = coord_sat;
          sel_d   = 1'b1;
        end else begin
          pix_y_d = coord_sat;
        end
      end
      tsac_pkg::ST_OUT: begin
        if (out_free) begin
          m_data_d  = {4'b0000, pix_y_q, pix_x_q, avg_y_q, avg_x_q};
          m_valid_d = 1'b1;
          sum_x_d   = '0;
          sum_y_d   = '0;
          cnt_d     = '0;
        end
      end
      default: ;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= tsac_pkg::ST_IDLE;
      sum_x_q        <= '0;
      sum_y_q        <= '0;
      cnt_q          <= '0;
      step_q         <= '0;
      sel_q          <= 1'b0;
      m_valid_q      <= 1'b0;
      sample_count_q <= tsac_pkg::SampleCountRst;
      offset_x_q     <= tsac_pkg::OffsetRst;
      offset_y_q     <= tsac_pkg::OffsetRst;
      gain_x_q       <= tsac_pkg::GainXRst;
      gain_y_q       <= tsac_pkg::GainYRst;
    end else begin
      state_q   <= state_d;
      sum_x_q   <= sum_x_d;
      sum_y_q   <= sum_y_d;
      cnt_q     <= cnt_d;
      step_q    <= step_d;
      sel_q     <= sel_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tsac_pkg::REG_SAMPLE_COUNT:
            sample_count_q <= cfg_wdata_i[tsac_pkg::CountW-1:0];
          tsac_pkg::REG_OFFSET_X: offset_x_q <= cfg_wdata_i[tsac_pkg::RawW-1:0];
          tsac_pkg::REG_OFFSET_Y: offset_y_q <= cfg_wdata_i[tsac_pkg::RawW-1:0];
          tsac_pkg::REG_GAIN_X:   gain_x_q   <= $signed(cfg_wdata_i);
          tsac_pkg::REG_GAIN_Y:   gain_y_q   <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    div_n_q  <= div_n_d;
    dq_q     <= dq_d;
    rem_q    <= rem_d;
    prod_q   <= prod_d;
    avg_x_q  <= avg_x_d;
    avg_y_q  <= avg_y_d;
    pix_x_q  <= pix_x_d;
    pix_y_q  <= pix_y_d;
    m_data_q <= m_data_d;
  end

endmodule

FILE: tb/touch_sample_average_calibrate_tb.sv
`timescale 1ns / 1ps

module touch_sample_average_calibrate_tb;
  import tsac_pkg::*;

  localparam int          HalfPeriod = 6;
  localparam int          ResetCycles = 5;
  localparam int          DrainCycles = 64;
  localparam int          WatchdogLimit = 2000;
  localparam int          PairTarget = 1650;
  localparam logic [RawW-1:0]    RawMax = '1;
  localparam logic [GainW-1:0]   GainMin = 17'h10000;
  localparam logic [GainW-1:0]   GainMax = 17'h0FFFF;
  localparam logic [GainW-1:0]   GainMinusOne = '1;
  // Indexes past the register list; writes to them must be dropped
  localparam logic [CfgIdxW-1:0] RegBeyond = CfgIdxW'(REG_GAIN_Y + 1);
  localparam logic [CfgIdxW-1:0] RegTop = '1;

  typedef struct packed {
    logic [RawW-1:0] avg_x;
    logic [RawW-1:0] avg_y;
    logic [RawW-1:0] pix_x;
    logic [RawW-1:0] pix_y;
  } touch_t;

  typedef enum logic {ROW_REG, ROW_PAIR} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgW-1:0]     wdata;
    logic [InDataW-1:0]  pair;
    bit                  typed;
    touch_t              want;
  } row_t;

  typedef enum int {SRC_NOISE, SRC_CLUSTER, SRC_EDGE} src_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [CfgW-1:0]      cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;

  // Calibration registers and accumulator as the block should hold them
  logic [CountW-1:0]        count_p = SampleCountRst;
  logic [RawW-1:0]          off_x_p = OffsetRst;
  logic [RawW-1:0]          off_y_p = OffsetRst;
  logic signed [GainW-1:0]  gain_x_p = GainXRst;
  logic signed [GainW-1:0]  gain_y_p = GainYRst;
  logic [SumW-1:0]          sum_x_p = '0;
  logic [SumW-1:0]          sum_y_p = '0;
  logic [CountW-1:0]        held_p = '0;

  touch_t  touch_exp_q[$];
  row_t    dir_rows[$];
  int      err_cnt = 0;
  int      pairs_sent = 0;
  int      idle_cyc = 0;
  bit      calm = 1'b0;
  int      rdy_left = 0;

  touch_sample_average_calibrate u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_count(logic [CountW-1:0] c);
    if (c == 0) return 1;
    if (c > MaxSamples) return int'(MaxSamples);
    return int'(c);
  endfunction

  // Offset, multiply by Q.16 gain, floor and clamp to the pixel range
  function automatic logic [RawW-1:0] to_pixel(logic [RawW-1:0] avg, logic [RawW-1:0] off,
                                               logic signed [GainW-1:0] gain);
    longint prod;
    longint q;
    prod = (longint'(avg) - longint'(off)) * longint'(gain);
    q = prod >>> FracW;
    if (q < 0) return '0;
    if (q > RawMax) return RawMax;
    return RawW'(q);
  endfunction

  // Add one conversion pair; report a touch once enough pairs are held
  function automatic bit average_pair(logic [InDataW-1:0] pair, output touch_t res);
    logic [RawW-1:0] ry;
    logic [RawW-1:0] rx;
    ry = {pair[7:0], pair[15:11]};
    rx = {pair[23:16], pair[31:27]};
    sum_y_p = sum_y_p + SumW'(ry);
    sum_x_p = sum_x_p + SumW'(rx);
    held_p = held_p + CountW'(1);
    res = '0;
    if (held_p < eff_count(count_p)) return 1'b0;
    res.avg_x = RawW'(sum_x_p / held_p);
    res.avg_y = RawW'(sum_y_p / held_p);
    res.pix_x = to_pixel(res.avg_x, off_x_p, gain_x_p);
    res.pix_y = to_pixel(res.avg_y, off_y_p, gain_y_p);
    sum_x_p = '0;
    sum_y_p = '0;
    held_p = '0;
    return 1'b1;
  endfunction

  function automatic logic [InDataW-1:0] pack_pair(logic [ByteW-1:0] yh, logic [ByteW-1:0] yl,
                                                   logic [ByteW-1:0] xh, logic [ByteW-1:0] xl);
    return {xl, xh, yl, yh};
  endfunction

  // Split a raw value into reply bytes, with junk in the dropped low bits
  function automatic logic [2*ByteW-1:0] reply_bytes(logic [RawW-1:0] raw);
    return {raw[12:5], raw[4:0], 3'($urandom)};
  endfunction

  function automatic logic [RawW-1:0] gen_raw(src_e src, logic [RawW-1:0] base, int jit);
    case (src)
      SRC_CLUSTER: return RawW'(int'(base) + $urandom_range(0, 2 * jit) - jit);
      SRC_EDGE:    return $urandom_range(0, 1) ? RawMax : '0;
      default:     return RawW'($urandom);
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CfgW'(RawMax);
      2:       return CfgW'(OffsetRst);
      default: return CfgW'($urandom_range(0, RawMax));
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return GainMin;
      1:       return GainMax;
      2:       return CfgW'($signed(GainXRst));
      3:       return CfgW'($signed(GainYRst));
      4:       return CfgW'($urandom_range(0, 16) - 8);
      default: return CfgW'($urandom);
    endcase
  endfunction

  function automatic row_t reg_row(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] v);
    row_t r;
    r = '{kind: ROW_REG, idx: idx, wdata: v, pair: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t pair_row(logic [InDataW-1:0] pair, bit typed, touch_t want);
    row_t r;
    r = '{kind: ROW_PAIR, idx: '0, wdata: '0, pair: pair, typed: typed, want: want};
    return r;
  endfunction

  function automatic void check_field(string name, logic [RawW-1:0] want, logic [RawW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // Write one register; called and returns at a falling edge
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] v);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = v;
    @(posedge clk_i);
    case (idx)
      REG_SAMPLE_COUNT: count_p = v[CountW-1:0];
      REG_OFFSET_X:     off_x_p = v[RawW-1:0];
      REG_OFFSET_Y:     off_y_p = v[RawW-1:0];
      REG_GAIN_X:       gain_x_p = $signed(v);
      REG_GAIN_Y:       gain_y_p = $signed(v);
      default:          ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Offer one pair until accepted; a typed row overrides the predicted touch
  task automatic send_pair(logic [InDataW-1:0] pair, bit typed = 1'b0, touch_t want = '0);
    int     gap;
    touch_t res;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = pair;
    do @(posedge clk_i); while (!s_axis_tready);
    pairs_sent++;
    if (average_pair(pair, res)) touch_exp_q.push_back(typed ? want : res);
    @(negedge clk_i);
  endtask

  // Hold the sender until every touch is out and the block has gone quiet
  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (touch_exp_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Receiver: random stretches of ready and stall, always ready when calm
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
      rdy_left <= 0;
    end else if (rdy_left > 0) begin
      rdy_left <= rdy_left - 1;
    end else if ($urandom_range(0, 2) != 0) begin
      m_axis_tready <= 1'b1;
      rdy_left <= $urandom_range(0, 19);
    end else begin
      m_axis_tready <= 1'b0;
      rdy_left <= gap_len();
    end
  end

  // Check each touch against the oldest expectation; watch for a hang
  always @(posedge clk_i) begin
    touch_t want;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cyc = 0;
    end else begin
      idle_cyc++;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (touch_exp_q.size() == 0) begin
        $error("touch result with no pair pending: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = touch_exp_q.pop_front();
        check_field("avg_x", want.avg_x, m_axis_tdata[12:0]);
        check_field("avg_y", want.avg_y, m_axis_tdata[25:13]);
        check_field("pixel_x", want.pix_x, m_axis_tdata[38:26]);
        check_field("pixel_y", want.pix_y, m_axis_tdata[51:39]);
        check_field("pad", '0, RawW'(m_axis_tdata[55:52]));
      end
    end
    if (idle_cyc >= WatchdogLimit) begin
      $display("touch_sample_average_calibrate_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [2*ByteW-1:0] yb;
    logic [2*ByteW-1:0] xb;
    logic [RawW-1:0]    base_x;
    logic [RawW-1:0]    base_y;
    src_e               src;
    int                 jit;
    int                 eff;
    int                 n_pairs;

    // Directed table: defaults, range extremes, floor at zero, count cases
    dir_rows.push_back(reg_row(REG_SAMPLE_COUNT, 1));
    dir_rows.push_back(pair_row(pack_pair(8'h76, 8'hC0, 8'h76, 8'hC7), 0, '0));
    dir_rows.push_back(pair_row(pack_pair(8'h30, 8'h18, 8'hB2, 8'h40), 0, '0));
    dir_rows.push_back(reg_row(REG_OFFSET_X, 0));
    dir_rows.push_back(reg_row(REG_OFFSET_Y, 0));
    dir_rows.push_back(reg_row(REG_GAIN_X, GainMax));
    dir_rows.push_back(reg_row(REG_GAIN_Y, GainMax));
    dir_rows.push_back(pair_row(pack_pair(8'h00, 8'h00, 8'h00, 8'h00), 1, '{0, 0, 0, 0}));
    dir_rows.push_back(pair_row(pack_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1,
                                '{8191, 8191, 8190, 8190}));
    dir_rows.push_back(pair_row(pack_pair(8'hFF, 8'hFF, 8'h00, 8'h00), 1,
                                '{0, 8191, 0, 8190}));
    dir_rows.push_back(reg_row(REG_OFFSET_X, CfgW'(RawMax)));
    dir_rows.push_back(reg_row(REG_OFFSET_Y, CfgW'(RawMax)));
    dir_rows.push_back(reg_row(REG_GAIN_X, GainMin));
    dir_rows.push_back(reg_row(REG_GAIN_Y, GainMin));
    dir_rows.push_back(pair_row(pack_pair(8'h00, 8'h00, 8'h00, 8'h00), 1,
                                '{0, 0, 8191, 8191}));
    dir_rows.push_back(pair_row(pack_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF), 1,
                                '{8191, 8191, 0, 0}));
    dir_rows.push_back(pair_row(pack_pair(8'h00, 8'h07, 8'h80, 8'hF8), 0, '0));
    // Tiny negative product floors to -1 and clamps to zero
    dir_rows.push_back(reg_row(REG_OFFSET_X, 0));
    dir_rows.push_back(reg_row(REG_GAIN_X, GainMinusOne));
    dir_rows.push_back(pair_row(pack_pair(8'h00, 8'h00, 8'h00, 8'h08), 1,
                                '{1, 0, 0, 8191}));
    // Zero count behaves as one
    dir_rows.push_back(reg_row(REG_SAMPLE_COUNT, 0));
    dir_rows.push_back(pair_row(pack_pair(8'h12, 8'h34, 8'h56, 8'h78), 0, '0));
    dir_rows.push_back(pair_row(pack_pair(8'hA5, 8'h5A, 8'h3C, 8'hC3), 0, '0));
    // Lower the count while pairs are held
    dir_rows.push_back(reg_row(REG_GAIN_X, CfgW'($signed(GainXRst))));
    dir_rows.push_back(reg_row(REG_OFFSET_X, CfgW'(OffsetRst)));
    dir_rows.push_back(reg_row(REG_SAMPLE_COUNT, 4));
    dir_rows.push_back(pair_row(pack_pair(8'h10, 8'hFF, 8'hF0, 8'h00), 0, '0));
    dir_rows.push_back(pair_row(pack_pair(8'h20, 8'h08, 8'hE0, 8'h10), 0, '0));
    dir_rows.push_back(pair_row(pack_pair(8'h40, 8'h80, 8'h01, 8'hF8), 0, '0));
    dir_rows.push_back(reg_row(REG_SAMPLE_COUNT, 2));
    dir_rows.push_back(pair_row(pack_pair(8'h7F, 8'hF8, 8'h02, 8'h00), 0, '0));
    // Writes past the register list leave everything alone
    dir_rows.push_back(reg_row(RegBeyond, '1));
    dir_rows.push_back(reg_row(RegTop, '0));
    dir_rows.push_back(pair_row(pack_pair(8'h55, 8'hAA, 8'hAA, 8'h55), 0, '0));
    dir_rows.push_back(pair_row(pack_pair(8'h99, 8'h66, 8'h66, 8'h99), 0, '0));

    // Release reset at a falling edge
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Walk the directed table; registers change only with the block idle
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        send_pair(dir_rows[i].pair, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases: reprogram, then a stream of pairs from one source shape
    while (pairs_sent < PairTarget) begin
      wait_idle();
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 19))
          0:       write_reg(REG_SAMPLE_COUNT, 0);
          1:       write_reg(REG_SAMPLE_COUNT, CfgW'(MaxSamples));
          2:       write_reg(REG_SAMPLE_COUNT, '1);
          3:       write_reg(REG_SAMPLE_COUNT, CfgW'($urandom_range(65, 126)));
          4:       write_reg(REG_SAMPLE_COUNT, CfgW'(SampleCountRst));
          5, 6, 7: write_reg(REG_SAMPLE_COUNT, CfgW'($urandom_range(9, 32)));
          default: write_reg(REG_SAMPLE_COUNT, CfgW'($urandom_range(1, 8)));
        endcase
      end
      if ($urandom_range(0, 1)) write_reg(REG_OFFSET_X, pick_offset());
      if ($urandom_range(0, 1)) write_reg(REG_OFFSET_Y, pick_offset());
      if ($urandom_range(0, 1)) write_reg(REG_GAIN_X, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_GAIN_Y, pick_gain());
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CfgIdxW'($urandom_range(RegBeyond, RegTop)), CfgW'($urandom));
      end
      eff = eff_count(count_p);
      n_pairs = (eff == MaxSamples) ? eff : eff * $urandom_range(1, 3);
      // Leave some pairs held so the next setting meets a partial sum
      if ($urandom_range(0, 2) == 0) n_pairs += $urandom_range(0, eff - 1);
      src = src_e'($urandom_range(SRC_NOISE, SRC_EDGE));
      base_x = RawW'($urandom);
      base_y = RawW'($urandom);
      jit = $urandom_range(0, 64);
      repeat (n_pairs) begin
        yb = reply_bytes(gen_raw(src, base_y, jit));
        xb = reply_bytes(gen_raw(src, base_x, jit));
        send_pair(pack_pair(yb[15:8], yb[7:0], xb[15:8], xb[7:0]));
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("touch_sample_average_calibrate_tb OK");
    end else begin
      $display("touch_sample_average_calibrate_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: touch_sample_average_calibrate.f
rtl/core/tsac_pkg.sv
rtl/core/touch_sample_average_calibrate.sv
tb/touch_sample_average_calibrate_tb.sv
